// ----- rtl/core/hsm_transition_sequencer_defines.svh -----
// ============================================================================
// hsm_transition_sequencer_defines
// Assertion macros shared by the transition sequencer RTL.
// ============================================================================
`ifndef HSM_TRANSITION_SEQUENCER_DEFINES_SVH
`define HSM_TRANSITION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsm_transition_sequencer: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsm_transition_sequencer: assertion failed");

`endif

// ----- rtl/core/hsm_pkg.sv -----
// ============================================================================
// hsm_pkg
// Types and constants of the hierarchical state machine transition sequencer.
// ============================================================================
package hsm_pkg;

    localparam int NumStatesDefault = 16;
    localparam int MaxDepthDefault  = 10;

    localparam int ReqW    = 2;
    localparam int TargetW = 4;
    localparam int ParentW = 5;
    localparam int IndexW  = 5;
    localparam int CountW  = 5;

    localparam logic [CountW-1:0] StateCountReset = CountW'(16);

    localparam logic [ReqW-1:0] REQ_LOAD  = 2'd0;
    localparam logic [ReqW-1:0] REQ_INIT  = 2'd1;
    localparam logic [ReqW-1:0] REQ_TRANS = 2'd2;

    typedef enum logic [1:0] {
        KIND_EXIT  = 2'd0,
        KIND_ENTER = 2'd1,
        KIND_OK    = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_INIT  = 2'd1,
        OP_TRANS = 2'd2,
        OP_ERROR = 2'd3
    } t_op;

    typedef struct packed {
        logic [ReqW-1:0]    req_type;
        logic [TargetW-1:0] target_state;
        logic [ParentW-1:0] parent_state;
    } t_request;

    typedef struct packed {
        t_kind             result_kind;
        logic [IndexW-1:0] state_index;
        logic              last;
    } t_result;

    typedef struct packed {
        t_op                op;
        logic [TargetW-1:0] target;
        logic [ParentW-1:0] parent;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [3:0] {
        B_IDLE,
        B_OLD_STEP,
        B_OLD_WAIT,
        B_NEW_STEP,
        B_NEW_WAIT,
        B_MATCH,
        B_EXIT,
        B_ENTER,
        B_OK
    } t_back_state;

endpackage

// ----- rtl/core/hsm_front.sv -----
// ============================================================================
// hsm_front
// Holds the state count register, checks each request word and classifies it
// into a command for the command queue.
// ============================================================================
module hsm_front #(
    parameter int NUM_STATES = hsm_pkg::NumStatesDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hsm_pkg::CountW-1:0]        i_cfg_data,
    input  logic                              i_start,
    input  hsm_pkg::t_request                 i_req,
    input  hsm_pkg::t_q_stat                  i_q_stat,
    output logic                              o_push,
    output hsm_pkg::t_cmd                     o_cmd
);
    import hsm_pkg::*;

    localparam int IW   = $clog2(NUM_STATES + 1);
    localparam int CMPW = (IW > ParentW) ? IW : ParentW;
    localparam logic [CMPW-1:0] TopCode = CMPW'(NUM_STATES);

    logic [CountW-1:0] r_state_count;
    logic [CMPW-1:0]   count_x;
    logic [CMPW-1:0]   active_count;
    logic [CMPW-1:0]   target_x;
    logic [CMPW-1:0]   parent_x;
    logic              target_ok;
    logic              parent_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= StateCountReset;
        end else if (i_cfg_we) begin
            r_state_count <= i_cfg_data;
        end
    end

    always_comb begin
        count_x      = CMPW'(r_state_count);
        active_count = (count_x < TopCode) ? count_x : TopCode;
        target_x     = CMPW'(i_req.target_state);
        parent_x     = CMPW'(i_req.parent_state);
        target_ok    = target_x < active_count;
        parent_ok    = (parent_x == TopCode) || (parent_x < active_count);
    end

    always_comb begin
        o_push        = i_start && !i_q_stat.full;
        o_cmd.target  = i_req.target_state;
        o_cmd.parent  = i_req.parent_state;
        case (i_req.req_type)
            REQ_LOAD: begin
                o_cmd.op = (target_ok && parent_ok) ? OP_LOAD : OP_ERROR;
            end
            REQ_INIT: begin
                o_cmd.op = target_ok ? OP_INIT : OP_ERROR;
            end
            REQ_TRANS: begin
                o_cmd.op = target_ok ? OP_TRANS : OP_ERROR;
            end
            default: begin
                o_cmd.op = OP_ERROR;
            end
        endcase
    end

endmodule

// ----- rtl/core/hsm_cmdq.sv -----
// ============================================================================
// hsm_cmdq
// Two-entry command queue between the request front and the sequencer back.
// ============================================================================
module hsm_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hsm_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output hsm_pkg::t_cmd    o_head,
    output hsm_pkg::t_q_stat o_stat
);
    import hsm_pkg::*;

    localparam int Depth = 2;
    localparam int PW    = $clog2(Depth);

    t_cmd          r_q [Depth];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    always_comb begin
        o_stat.full  = r_count == (PW+1)'(Depth);
        o_stat.empty = r_count == '0;
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        o_head       = r_q[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/core/hsm_back.sv -----
// ============================================================================
// hsm_back
// Executes queued commands: keeps the parent table and the current state,
// walks both ancestor chains, strips the shared top and emits the words.
// ============================================================================
module hsm_back #(
    parameter int NUM_STATES = hsm_pkg::NumStatesDefault,
    parameter int MAX_DEPTH  = hsm_pkg::MaxDepthDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hsm_pkg::t_q_stat i_q_stat,
    input  hsm_pkg::t_cmd    i_head,
    output logic             o_pop,
    output logic             o_valid,
    output hsm_pkg::t_result o_result
);
    import hsm_pkg::*;

    localparam int SW  = $clog2(NUM_STATES);
    localparam int IW  = $clog2(NUM_STATES + 1);
    localparam int CW  = $clog2(MAX_DEPTH);
    localparam int PD  = MAX_DEPTH - 1;
    localparam int PIW = (PD > 1) ? $clog2(PD) : 1;
    localparam logic [IW-1:0]     TopCode   = IW'(NUM_STATES);
    localparam logic [IndexW-1:0] StatusIdx = IndexW'(NUM_STATES);

    t_back_state r_state;
    t_back_state n_state;

    logic [IW-1:0] r_mem [NUM_STATES];
    logic          r_pvld [NUM_STATES];
    logic [IW-1:0] r_rd_data;
    logic          r_rd_vld;

    logic [SW-1:0] r_old [PD];
    logic [SW-1:0] r_new [PD];
    logic [IW-1:0] r_s;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_no;
    logic [CW-1:0] r_nn;
    logic [CW-1:0] r_i;
    logic [SW-1:0] r_tgt;
    logic [SW-1:0] r_cur;
    logic          r_cur_vld;
    logic          r_valid;
    t_result       r_result;
    logic          n_valid;
    t_result       n_result;

    logic [SW-1:0]  hd_tgt;
    logic [IW-1:0]  hd_par;
    logic           at_top;
    logic           path_full;
    logic [IW-1:0]  fetched;
    logic [CW-1:0]  no_m1;
    logic [CW-1:0]  nn_m1;
    logic [PIW-1:0] old_addr;
    logic [SW-1:0]  old_rd;
    logic [SW-1:0]  new_rd;
    logic           match;

    always_comb begin
        o_pop     = (r_state == B_IDLE) && !i_q_stat.empty;
        hd_tgt    = SW'(i_head.target);
        hd_par    = IW'(i_head.parent);
        at_top    = r_s == TopCode;
        path_full = r_n == CW'(PD);
        fetched   = r_rd_vld ? r_rd_data : TopCode;
        no_m1     = r_no - 1'b1;
        nn_m1     = r_nn - 1'b1;
        old_addr  = (r_state == B_MATCH) ? no_m1[PIW-1:0] : r_i[PIW-1:0];
        old_rd    = r_old[old_addr];
        new_rd    = r_new[nn_m1[PIW-1:0]];
        match     = (r_no != '0) && (r_nn != '0) && (old_rd == new_rd);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (o_pop && i_head.op == OP_TRANS && r_cur_vld) begin
                    n_state = B_OLD_STEP;
                end
            end
            B_OLD_STEP: begin
                if (at_top) begin
                    n_state = B_NEW_STEP;
                end else if (path_full) begin
                    n_state = B_IDLE;
                end else begin
                    n_state = B_OLD_WAIT;
                end
            end
            B_OLD_WAIT: begin
                n_state = B_OLD_STEP;
            end
            B_NEW_STEP: begin
                if (at_top) begin
                    n_state = B_MATCH;
                end else if (path_full) begin
                    n_state = B_IDLE;
                end else begin
                    n_state = B_NEW_WAIT;
                end
            end
            B_NEW_WAIT: begin
                n_state = B_NEW_STEP;
            end
            B_MATCH: begin
                if (match) begin
                    n_state = B_MATCH;
                end else if (r_no != '0) begin
                    n_state = B_EXIT;
                end else if (r_nn != '0) begin
                    n_state = B_ENTER;
                end else begin
                    n_state = B_OK;
                end
            end
            B_EXIT: begin
                if (r_i == no_m1) begin
                    n_state = (r_nn != '0) ? B_ENTER : B_OK;
                end
            end
            B_ENTER: begin
                if (r_nn == CW'(1)) begin
                    n_state = B_OK;
                end
            end
            B_OK: begin
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid  = 1'b0;
        n_result = '{result_kind: KIND_OK, state_index: StatusIdx, last: 1'b1};
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    n_valid = 1'b1;
                    case (i_head.op)
                        OP_LOAD: begin
                            n_result.result_kind = KIND_OK;
                        end
                        OP_INIT: begin
                            n_result.result_kind = KIND_ENTER;
                            n_result.state_index = IndexW'(hd_tgt);
                        end
                        OP_TRANS: begin
                            n_valid              = !r_cur_vld;
                            n_result.result_kind = KIND_ERROR;
                        end
                        default: begin
                            n_result.result_kind = KIND_ERROR;
                        end
                    endcase
                end
            end
            B_OLD_STEP, B_NEW_STEP: begin
                n_valid              = !at_top && path_full;
                n_result.result_kind = KIND_ERROR;
            end
            B_EXIT: begin
                n_valid  = 1'b1;
                n_result = '{result_kind: KIND_EXIT, state_index: IndexW'(old_rd),
                             last: 1'b0};
            end
            B_ENTER: begin
                n_valid  = 1'b1;
                n_result = '{result_kind: KIND_ENTER, state_index: IndexW'(new_rd),
                             last: 1'b0};
            end
            B_OK: begin
                n_valid = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_valid   <= 1'b0;
            r_cur_vld <= 1'b0;
            r_cur     <= '0;
            for (int k = 0; k < NUM_STATES; k++) begin
                r_pvld[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (o_pop && i_head.op == OP_INIT) begin
                r_cur_vld <= 1'b1;
                r_cur     <= hd_tgt;
            end else if (r_state == B_OK) begin
                r_cur <= r_tgt;
            end
            if (o_pop && i_head.op == OP_LOAD) begin
                r_pvld[hd_tgt] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == OP_LOAD) begin
            r_mem[hd_tgt] <= hd_par;
        end
        r_rd_data <= r_mem[r_s[SW-1:0]];
        r_rd_vld  <= r_pvld[r_s[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        case (r_state)
            B_IDLE: begin
                r_tgt <= hd_tgt;
                r_s   <= IW'(r_cur);
                r_n   <= '0;
            end
            B_OLD_STEP: begin
                if (at_top) begin
                    r_no <= r_n;
                    r_s  <= IW'(r_tgt);
                    r_n  <= '0;
                end else if (!path_full) begin
                    r_old[r_n[PIW-1:0]] <= r_s[SW-1:0];
                    r_n                 <= r_n + 1'b1;
                end
            end
            B_NEW_STEP: begin
                if (at_top) begin
                    r_nn <= r_n;
                end else if (!path_full) begin
                    r_new[r_n[PIW-1:0]] <= r_s[SW-1:0];
                    r_n                 <= r_n + 1'b1;
                end
            end
            B_OLD_WAIT, B_NEW_WAIT: begin
                r_s <= fetched;
            end
            B_MATCH: begin
                r_i <= '0;
                if (match) begin
                    r_no <= no_m1;
                    r_nn <= nn_m1;
                end
            end
            B_EXIT: begin
                r_i <= r_i + 1'b1;
            end
            B_ENTER: begin
                r_nn <= nn_m1;
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/core/hsm_transition_sequencer.sv -----
// ============================================================================
// hsm_transition_sequencer
// Transition sequencer for a hierarchical state machine with a parent table.
// ============================================================================
// A request word is taken when start is high and busy is low; up to two
// requests wait in a command queue, and busy is high while it is full. Each
// result word is shown on o_result for one cycle with o_valid high and must
// be taken then, since the receiver cannot stall. A load, an init, or a
// request rejected at the front or before any init gives its single word in
// the cycle after it leaves the queue. A transition walks the old and new
// ancestor chains, strips their shared part and then gives the exits and
// enters; each chain entry takes a step state and a wait state because the
// parent table is read through one registered memory port. The words of one
// transition come in consecutive cycles, and the last word has last set.
// ============================================================================
`include "hsm_transition_sequencer_defines.svh"

module hsm_transition_sequencer #(
    parameter int NUM_STATES = hsm_pkg::NumStatesDefault,
    parameter int MAX_DEPTH  = hsm_pkg::MaxDepthDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [hsm_pkg::CountW-1:0] i_cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  hsm_pkg::t_request          i_req,
    output logic                       o_valid,
    output hsm_pkg::t_result           o_result
);
    import hsm_pkg::*;

    localparam logic [IndexW-1:0] StatusIdx = IndexW'(NUM_STATES);

    t_q_stat q_stat;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    pop;

    hsm_front #(
        .NUM_STATES(NUM_STATES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_start   (start),
        .i_req     (i_req),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    hsm_cmdq u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_head (head_cmd),
        .o_stat (q_stat)
    );

    hsm_back #(
        .NUM_STATES(NUM_STATES),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_stat(q_stat),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    assign busy = q_stat.full;

    `HSM_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, o_valid && !o_result.last, o_valid)
    `HSM_ASSERT_IMPLIES(a_status_word, i_clk, i_rst_n, o_valid && (o_result.result_kind == KIND_OK || o_result.result_kind == KIND_ERROR), o_result.last && o_result.state_index == StatusIdx)
    `HSM_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, start && !busy, !q_stat.empty)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the hierarchical state machine transition sequencer.
// ============================================================================
// Requests are driven on the command port with random gaps. Every accepted
// request is run through a local model of the parent table and current state,
// which queues the exit, enter and status words the block must produce. Each
// result word is checked field by field against the oldest queued word.
// Directed tests cover the error paths, ancestor walks and state count limits.
// Random traffic then loads whole trees, inits and transitions under several
// state counts and sender idle rates.
// ============================================================================
module testbench;
    import hsm_pkg::*;

    localparam int NUM_STATES     = NumStatesDefault;
    localparam int MAX_DEPTH      = MaxDepthDefault;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;
    localparam logic [ReqW-1:0] REQ_BAD = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CountW-1:0] i_cfg_data;
    logic              start;
    logic              busy;
    t_request          i_req;
    logic              o_valid;
    t_result           o_result;

    logic [ParentW-1:0] parent_of [NUM_STATES];
    logic [TargetW-1:0] active_state;
    logic               active_valid;
    logic [CountW-1:0]  states_in_use;
    int                 chain_buf [MAX_DEPTH];

    t_result pending_words [$];
    int      mismatch_count;
    int      idle_cycles;
    int      send_idle_pct;

    hsm_transition_sequencer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    function automatic void push_word(input t_kind kind, input int idx, input logic last);
        t_result w;
        w.result_kind = kind;
        w.state_index = IndexW'(idx);
        w.last        = last;
        pending_words.push_back(w);
    endfunction

    // Collects the states from the leaf up to the top level, or -1 if too deep.
    function automatic int walk_chain(input int leaf);
        int n;
        int s;
        n = 0;
        s = leaf;
        while (s < NUM_STATES) begin
            if (n >= MAX_DEPTH - 1) begin
                return -1;
            end
            chain_buf[n] = s;
            n++;
            s = parent_of[s];
        end
        return n;
    endfunction

    task automatic compute_notifications(input t_request r);
        int cnt;
        int n_old;
        int n_new;
        int common;
        int cur_chain [MAX_DEPTH];
        cnt = (states_in_use < NUM_STATES) ? int'(states_in_use) : NUM_STATES;
        case (r.req_type)
            REQ_LOAD: begin
                if (r.target_state >= cnt ||
                    (r.parent_state != NUM_STATES && r.parent_state >= cnt)) begin
                    push_word(KIND_ERROR, NUM_STATES, 1'b1);
                end else begin
                    parent_of[r.target_state] = r.parent_state;
                    push_word(KIND_OK, NUM_STATES, 1'b1);
                end
            end
            REQ_INIT: begin
                if (r.target_state >= cnt) begin
                    push_word(KIND_ERROR, NUM_STATES, 1'b1);
                end else begin
                    active_state = r.target_state;
                    active_valid = 1'b1;
                    push_word(KIND_ENTER, r.target_state, 1'b1);
                end
            end
            REQ_TRANS: begin
                n_old = -1;
                n_new = -1;
                if (r.target_state < cnt && active_valid) begin
                    n_old = walk_chain(active_state);
                    for (int i = 0; i < MAX_DEPTH; i++) begin
                        cur_chain[i] = chain_buf[i];
                    end
                    if (n_old >= 0) begin
                        n_new = walk_chain(r.target_state);
                    end
                end
                if (n_old < 0 || n_new < 0) begin
                    push_word(KIND_ERROR, NUM_STATES, 1'b1);
                end else begin
                    common = 0;
                    while (common < n_old && common < n_new &&
                           cur_chain[n_old - 1 - common] == chain_buf[n_new - 1 - common]) begin
                        common++;
                    end
                    for (int i = 0; i < n_old - common; i++) begin
                        push_word(KIND_EXIT, cur_chain[i], 1'b0);
                    end
                    for (int i = n_new - common - 1; i >= 0; i--) begin
                        push_word(KIND_ENTER, chain_buf[i], 1'b0);
                    end
                    push_word(KIND_OK, NUM_STATES, 1'b1);
                    active_state = r.target_state;
                end
            end
            default: begin
                push_word(KIND_ERROR, NUM_STATES, 1'b1);
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [ReqW-1:0] kind, input logic [TargetW-1:0] tgt,
                                input logic [ParentW-1:0] par);
        t_request w;
        w.req_type     = kind;
        w.target_state = tgt;
        w.parent_state = par;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        start = 1'b1;
        i_req = w;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        compute_notifications(w);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_state_count(input logic [CountW-1:0] value);
        wait_drained();
        i_cfg_data = value;
        i_cfg_we   = 1'b1;
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
        states_in_use = value;
    endtask

    always @(posedge i_clk) begin : check_words
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d index %0d last %0d",
                                          o_result.result_kind, o_result.state_index,
                                          o_result.last));
            end else begin
                want = pending_words.pop_front();
                if (o_result.result_kind !== want.result_kind) begin
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              o_result.result_kind, want.result_kind));
                end
                if (o_result.state_index !== want.state_index) begin
                    report_mismatch($sformatf("state_index %0d, expected %0d",
                                              o_result.state_index, want.state_index));
                end
                if (o_result.last !== want.last) begin
                    report_mismatch($sformatf("last %0d, expected %0d",
                                              o_result.last, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_early_errors();
        send_request(REQ_TRANS, 4'd5, 5'd0);
        send_request(REQ_BAD, 4'd15, 5'd31);
    endtask

    task automatic test_parent_loads();
        send_request(REQ_LOAD, 4'd15, 5'd16);
        send_request(REQ_LOAD, 4'd0, 5'd17);
        send_request(REQ_LOAD, 4'd1, 5'd31);
        send_request(REQ_LOAD, 4'd1, 5'd0);
        send_request(REQ_LOAD, 4'd2, 5'd1);
        send_request(REQ_LOAD, 4'd3, 5'd2);
        send_request(REQ_LOAD, 4'd4, 5'd0);
        send_request(REQ_LOAD, 4'd5, 5'd15);
    endtask

    task automatic test_transitions();
        send_request(REQ_INIT, 4'd3, 5'd0);
        send_request(REQ_TRANS, 4'd3, 5'd0);
        send_request(REQ_TRANS, 4'd5, 5'd0);
        send_request(REQ_TRANS, 4'd4, 5'd0);
        send_request(REQ_TRANS, 4'd0, 5'd0);
        send_request(REQ_TRANS, 4'd3, 5'd0);
    endtask

    task automatic test_cycle_rejected();
        send_request(REQ_LOAD, 4'd14, 5'd13);
        send_request(REQ_LOAD, 4'd13, 5'd14);
        send_request(REQ_TRANS, 4'd14, 5'd0);
    endtask

    task automatic test_state_count();
        write_state_count(5'd4);
        send_request(REQ_LOAD, 4'd5, 5'd16);
        send_request(REQ_LOAD, 4'd2, 5'd4);
        send_request(REQ_INIT, 4'd4, 5'd0);
        write_state_count(5'd2);
        send_request(REQ_TRANS, 4'd1, 5'd0);
        write_state_count(5'd0);
        send_request(REQ_INIT, 4'd0, 5'd0);
        send_request(REQ_LOAD, 4'd0, 5'd16);
        write_state_count(5'd31);
        send_request(REQ_TRANS, 4'd15, 5'd0);
        write_state_count(5'd1);
        send_request(REQ_TRANS, 4'd0, 5'd0);
        write_state_count(5'd16);
    endtask

    task automatic load_random_tree();
        int shape;
        int p;
        shape = $urandom_range(2);
        for (int s = 0; s < NUM_STATES; s++) begin
            case (shape)
                0: p = (s == 0) ? NUM_STATES : s - 1;
                1: begin
                    p = $urandom_range(s);
                    if (p == s) begin
                        p = NUM_STATES;
                    end
                end
                default: p = $urandom_range(NUM_STATES);
            endcase
            send_request(REQ_LOAD, TargetW'(s), ParentW'(p));
        end
    endtask

    function automatic logic [CountW-1:0] pick_state_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) begin
            return CountW'(16);
        end else if (roll < 75) begin
            return CountW'($urandom_range(15, 10));
        end else if (roll < 85) begin
            return CountW'($urandom_range(9, 1));
        end else if (roll < 95) begin
            return CountW'($urandom_range(31, 17));
        end
        return CountW'(0);
    endfunction

    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int done;
        int roll;
        int par;
        send_idle_pct = idle_pct;
        done = 0;
        while (done < n_items) begin
            write_state_count(pick_state_count());
            for (int k = 0; k < 24 && done < n_items; k++) begin
                roll = $urandom_range(99);
                if (roll < 4) begin
                    load_random_tree();
                    done += NUM_STATES;
                end else begin
                    if (roll < 12) begin
                        par = ($urandom_range(99) < 80) ? $urandom_range(16) : $urandom_range(31);
                        send_request(REQ_LOAD, TargetW'($urandom_range(15)), ParentW'(par));
                    end else if (roll < 20) begin
                        send_request(REQ_INIT, TargetW'($urandom_range(15)), ParentW'($urandom));
                    end else if (roll < 24) begin
                        send_request(ReqW'($urandom), TargetW'($urandom), ParentW'($urandom));
                    end else begin
                        send_request(REQ_TRANS, TargetW'($urandom_range(15)), ParentW'($urandom));
                    end
                    done++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        start          = 1'b0;
        i_req          = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        send_idle_pct  = 35;
        for (int s = 0; s < NUM_STATES; s++) begin
            parent_of[s] = ParentW'(NUM_STATES);
        end
        active_state  = '0;
        active_valid  = 1'b0;
        states_in_use = StateCountReset;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_early_errors();
        test_parent_loads();
        test_transitions();
        test_cycle_rejected();
        test_state_count();
        test_random_traffic(35, 140);
        test_random_traffic(80, 140);
        test_random_traffic(0, 140);

        while (pending_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
